// ===== rtl/dsdq_pkg.sv =====
// package for the depth-sorted draw queue
// holds the entry type, status codes and default sizes; no dependencies
package dsdq_pkg;

    localparam int DSDQ_CAPACITY = 64;

    localparam int KIND_W   = 3;
    localparam int KEY_W    = 16;
    localparam int HANDLE_W = 32;
    localparam int ENTRY_W  = KIND_W + KEY_W + HANDLE_W;

    // result status codes
    localparam logic [1:0] STAT_PUSH_OK   = 2'd0;
    localparam logic [1:0] STAT_PUSH_DROP = 2'd1;
    localparam logic [1:0] STAT_SORTED    = 2'd2;
    localparam logic [1:0] STAT_EMPTY     = 2'd3;

    // action codes
    localparam logic ACT_PUSH  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [KEY_W-1:0]  key;
        logic [HANDLE_W-1:0]      handle;
    } t_entry;

endpackage

// ===== rtl/dsdq_if.sv =====
// item channels of the depth-sorted draw queue
// depends on dsdq_pkg for field widths
interface dsdq_cmd_if
    import dsdq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [KIND_W-1:0]          atom_kind;
    logic signed [KEY_W-1:0]    depth_key;
    logic [HANDLE_W-1:0]        payload_handle;

    modport source (output valid, action, atom_kind, depth_key, payload_handle,
                    input ready);
    modport sink   (input valid, action, atom_kind, depth_key, payload_handle,
                    output ready);
endinterface

interface dsdq_res_if
    import dsdq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 status;
    logic [KIND_W-1:0]          out_kind;
    logic signed [KEY_W-1:0]    out_key;
    logic [HANDLE_W-1:0]        out_handle;
    logic                       last_item;

    modport source (output valid, status, out_kind, out_key, out_handle, last_item,
                    input ready);
    modport sink   (input valid, status, out_kind, out_key, out_handle, last_item,
                    output ready);
endinterface

// ===== rtl/dsdq_ram.sv =====
// generic simple dual-port ram, one write and one read port, registered read
// no dependencies
module dsdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/depth_sorted_draw_queue.sv =====
// depth-sorted draw queue top level
// depends on dsdq_pkg, dsdq_if (channels) and dsdq_ram (entry store)

// A push item is placed at its sorted position on arrival, insertion-sort style:
// the stored entries with a greater key are moved up one place, one entry per
// cycle, through the single read and write port of the entry ram. A push answers
// at once with one result (accepted or dropped when CAPACITY-1 entries are
// stored); a push into an empty store is written in the cycle it is taken,
// while a push into a non-empty store first moves up each stored entry with a
// greater key and then writes the new entry; no new item is taken
// meanwhile. Equal keys keep their arrival order. A flush streams the store out
// in ascending key order, one entry per cycle while the output register can
// take it, marks the final entry with last_item and empties the store; a flush
// of an empty store gives a single marker result. Results sit in an output
// register; a new item is taken only while that register is empty or its
// result leaves in the same cycle.
module depth_sorted_draw_queue
    import dsdq_pkg::*;
#(
    parameter int CAPACITY = DSDQ_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dsdq_cmd_if.sink    i_cmd,
    dsdq_res_if.source  o_res
);
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam logic [ADDR_W-1:0] FULL_CNT = ADDR_W'(CAPACITY - 1);
    localparam logic [ADDR_W-1:0] ONE      = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] TWO      = ADDR_W'(2);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SHIFT = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]   r_pos, n_pos;     // insertion slot or flush index
    t_entry              r_new, n_new;

    // output register
    logic                r_ov, n_ov;
    logic [1:0]          r_ostat, n_ostat;
    t_entry              r_oent, n_oent;
    logic                r_olast, n_olast;

    // ram port
    logic                w_we, w_re;
    logic [ADDR_W-1:0]   w_waddr, w_raddr;
    t_entry              w_wdata;
    logic [ENTRY_W-1:0]  w_rdata;
    t_entry              w_rd;

    logic                w_ofree, w_acc;

    dsdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd    = t_entry'(w_rdata);
    assign w_ofree = !r_ov || o_res.ready;
    assign i_cmd.ready = (r_state == S_IDLE) && w_ofree;
    assign w_acc   = i_cmd.valid && i_cmd.ready;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_pos   = r_pos;
        n_new   = r_new;
        n_ov    = r_ov && !o_res.ready;
        n_ostat = r_ostat;
        n_oent  = r_oent;
        n_olast = r_olast;
        w_we    = 1'b0;
        w_waddr = r_pos;
        w_wdata = r_new;
        w_re    = 1'b0;
        w_raddr = r_pos;

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_ov    = 1'b1;
                    n_oent  = '0;
                    n_olast = 1'b1;
                    if (i_cmd.action == ACT_PUSH) begin
                        if (r_count >= FULL_CNT) begin
                            n_ostat = STAT_PUSH_DROP;
                        end else begin
                            n_ostat      = STAT_PUSH_OK;
                            n_new.kind   = i_cmd.atom_kind;
                            n_new.key    = i_cmd.depth_key;
                            n_new.handle = i_cmd.payload_handle;
                            n_pos        = r_count;
                            if (r_count == '0) begin
                                // empty store: write straight into slot zero
                                w_we    = 1'b1;
                                w_waddr = '0;
                                w_wdata = n_new;
                                n_count = ONE;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = r_count - ONE;
                                n_state = S_SHIFT;
                            end
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_ostat = STAT_EMPTY;
                        end else begin
                            n_ov    = r_ov && !o_res.ready;
                            w_re    = 1'b1;
                            w_raddr = '0;
                            n_pos   = '0;
                            n_state = S_FLUSH;
                        end
                    end
                end
            end
            S_SHIFT: begin
                // w_rd holds the entry at r_pos-1 unless r_pos is zero
                if (r_pos != '0 && w_rd.key > r_new.key) begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = w_rd;
                    n_pos   = r_pos - ONE;
                    if (r_pos != ONE) begin
                        w_re    = 1'b1;
                        w_raddr = r_pos - TWO;
                    end
                end else begin
                    w_we    = 1'b1;
                    w_waddr = r_pos;
                    w_wdata = r_new;
                    n_count = r_count + ONE;
                    n_state = S_IDLE;
                end
            end
            S_FLUSH: begin
                if (w_ofree) begin
                    n_ov    = 1'b1;
                    n_ostat = STAT_SORTED;
                    n_oent  = w_rd;
                    n_olast = (r_pos == r_count - ONE);
                    if (r_pos == r_count - ONE) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos + ONE;
                        w_re    = 1'b1;
                        w_raddr = r_pos + ONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
        r_pos   <= n_pos;
        r_new   <= n_new;
        r_ostat <= n_ostat;
        r_oent  <= n_oent;
        r_olast <= n_olast;
    end

    assign o_res.valid      = r_ov;
    assign o_res.status     = r_ostat;
    assign o_res.out_kind   = r_oent.kind;
    assign o_res.out_key    = r_oent.key;
    assign o_res.out_handle = r_oent.handle;
    assign o_res.last_item  = r_olast;

    // store never holds more than capacity minus one entries
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond capacity");

    // a dropped push leaves the store untouched
    a_drop_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_cmd.action == ACT_PUSH && r_count >= FULL_CNT) |=>
        ($stable(r_count) && r_state == S_IDLE))
        else $error("dropped push changed the store");

    // insertion slot never goes beyond the entry count of the store
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> (r_pos <= r_count))
        else $error("insertion slot out of range");

    // the flush ends only on a result marked last
    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && n_state == S_IDLE) |=> (r_ov && r_olast && r_count == '0))
        else $error("flush ended without a last result");
endmodule
